/* sv/rrfa_pkg.sv */
// Package: shared constants, types and the fault ID table of the fault annunciator.
`timescale 1ns / 1ps
package rrfa_pkg;

  localparam int NUM_ENTRIES = 32;
  localparam int ENTRY_LIMIT = (NUM_ENTRIES < 32) ? NUM_ENTRIES : 32;
  localparam int IDX_W = 5;

  localparam logic [12:0] WINDOW_MS = 13'd5000;

  // System modes
  localparam logic [1:0] MODE_STANDBY  = 2'd0;
  localparam logic [1:0] MODE_USER_RUN = 2'd1;
  localparam logic [1:0] MODE_NONE     = 2'd3;  // no mode seen since reset

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_TICK_PERIOD = 3'd0;
  localparam logic [2:0] REG_ENTRY_COUNT = 3'd1;
  localparam logic [2:0] REG_SHUTDOWN    = 3'd2;
  localparam logic [2:0] REG_NOSTART     = 3'd3;
  localparam logic [2:0] REG_REPORT_ONCE = 3'd4;

  typedef struct packed {
    logic [7:0]  tick_period_ms;
    logic [5:0]  entry_count;
    logic [31:0] shutdown_mask;
    logic [31:0] nostart_mask;
    logic [31:0] report_once_mask;
  } cfg_t;

  typedef struct packed {
    logic [6:0]  display_fault_id;
    logic        shutdown_request;
    logic        nostart_fault;
    logic [12:0] report_time_ms;
    logic [31:0] latched_faults;
  } result_t;

  // Build-time fault ID table; spare entries carry 54 + index.
  function automatic logic [6:0] fault_id(input logic [IDX_W-1:0] idx);
    logic [6:0] id;
    case (idx)
      5'd0:    id = 7'd2;
      5'd1:    id = 7'd3;
      5'd2:    id = 7'd5;
      5'd3:    id = 7'd6;
      5'd4:    id = 7'd32;
      5'd5:    id = 7'd40;
      5'd6:    id = 7'd41;
      5'd7:    id = 7'd44;
      5'd8:    id = 7'd46;
      5'd9:    id = 7'd48;
      5'd10:   id = 7'd49;
      5'd11:   id = 7'd50;
      5'd12:   id = 7'd59;
      5'd13:   id = 7'd63;
      5'd14:   id = 7'd68;
      5'd15:   id = 7'd69;
      5'd16:   id = 7'd70;
      5'd17:   id = 7'd71;
      5'd18:   id = 7'd72;
      5'd19:   id = 7'd73;
      5'd20:   id = 7'd74;
      default: id = 7'd54 + {2'b00, idx};
    endcase
    return id;
  endfunction

endpackage

/* sv/rrfa_tick_if.sv */
// Interface: tick channel carrying raw fault bits and system mode.
`timescale 1ns / 1ps
interface rrfa_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_faults;
  logic [1:0]  sys_mode;

  modport source (output valid, output raw_faults, output sys_mode, input ready);
  modport sink (input valid, input raw_faults, input sys_mode, output ready);
endinterface

/* sv/rrfa_report_if.sv */
// Interface: report channel carrying one annunciator result per tick.
`timescale 1ns / 1ps
interface rrfa_report_if;
  logic        valid;
  logic        ready;
  logic [6:0]  display_fault_id;
  logic        shutdown_request;
  logic        nostart_fault;
  logic [12:0] report_time_ms;
  logic [31:0] latched_faults;

  modport source (output valid, output display_fault_id, output shutdown_request,
                  output nostart_fault, output report_time_ms, output latched_faults,
                  input ready);
  modport sink (input valid, input display_fault_id, input shutdown_request,
                input nostart_fault, input report_time_ms, input latched_faults,
                output ready);
endinterface

/* sv/rrfa_cfg.sv */
// APB-style configuration register file of the fault annunciator.
`timescale 1ns / 1ps
module rrfa_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output rrfa_pkg::cfg_t cfg
);
  import rrfa_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period_ms   <= 8'd8;
      cfg.entry_count      <= 6'd21;
      cfg.shutdown_mask    <= 32'h0003_FFFF;
      cfg.nostart_mask     <= 32'h0003_FFE0;
      cfg.report_once_mask <= 32'h001C_0010;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TICK_PERIOD: cfg.tick_period_ms   <= pwdata[7:0];
        REG_ENTRY_COUNT: cfg.entry_count      <= pwdata[5:0];
        REG_SHUTDOWN:    cfg.shutdown_mask    <= pwdata;
        REG_NOSTART:     cfg.nostart_mask     <= pwdata;
        REG_REPORT_ONCE: cfg.report_once_mask <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TICK_PERIOD: prdata = {24'd0, cfg.tick_period_ms};
      REG_ENTRY_COUNT: prdata = {26'd0, cfg.entry_count};
      REG_SHUTDOWN:    prdata = cfg.shutdown_mask;
      REG_NOSTART:     prdata = cfg.nostart_mask;
      REG_REPORT_ONCE: prdata = cfg.report_once_mask;
      default:         prdata = 32'd0;
    endcase
  end

endmodule

/* sv/rrfa_core.sv */
// Annunciator state and the one-tick update: scan, latch, window and display rotation.
`timescale 1ns / 1ps
module rrfa_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [31:0]      raw_faults,
  input  logic [1:0]       sys_mode,
  input  rrfa_pkg::cfg_t   cfg,
  output rrfa_pkg::result_t res
);
  import rrfa_pkg::*;

  logic [IDX_W-1:0] scan_index, scan_index_next;
  logic [IDX_W-1:0] show_index, show_index_next;
  logic [31:0]      fault_flags, fault_flags_next;
  logic [12:0]      report_left, report_left_next;
  logic [12:0]      show_elapsed, show_elapsed_next;
  logic [1:0]       prev_mode;

  logic [5:0]       cnt;
  logic [IDX_W-1:0] show_sel, scan_sel;
  logic [13:0]      elapsed_sum;
  logic [5:0]       scan_nxt;
  logic [6:0]       shown_id;
  logic             fresh, hit, shut, nost;
  logic [12:0]      report_dec;

  always_comb begin
    // entries in use, clamped to 1..limit
    if (cfg.entry_count == 6'd0) begin
      cnt = 6'd1;
    end else if (cfg.entry_count > 6'(ENTRY_LIMIT)) begin
      cnt = 6'(ENTRY_LIMIT);
    end else begin
      cnt = cfg.entry_count;
    end

    // display rotation
    show_sel    = ({1'b0, show_index} >= cnt) ? '0 : show_index;
    elapsed_sum = {1'b0, show_elapsed} + {6'd0, cfg.tick_period_ms};
    show_elapsed_next = '0;
    shown_id          = '0;
    show_index_next   = '0;
    if (report_left != 13'd0) begin
      if (fault_flags[show_sel]) begin
        if (elapsed_sum > {1'b0, WINDOW_MS}) begin
          show_index_next = show_sel + 5'd1;
        end else begin
          show_elapsed_next = elapsed_sum[12:0];
          shown_id          = fault_id(show_sel);
          show_index_next   = show_sel;
        end
      end else begin
        show_index_next = show_sel + 5'd1;
      end
    end

    // window countdown, saturating
    report_dec = (report_left > {5'd0, cfg.tick_period_ms}) ?
                 report_left - {5'd0, cfg.tick_period_ms} : 13'd0;
    report_left_next = report_dec;

    // scan one entry
    scan_sel         = ({1'b0, scan_index} < cnt) ? scan_index : '0;
    hit              = raw_faults[scan_sel];
    fresh            = !fault_flags[scan_sel];
    shut             = hit && fresh && cfg.shutdown_mask[scan_sel];
    nost             = hit && cfg.nostart_mask[scan_sel];
    fault_flags_next = fault_flags;
    fault_flags_next[scan_sel] = hit;
    if (hit && (fresh || !cfg.report_once_mask[scan_sel])) begin
      report_left_next = WINDOW_MS;
    end
    scan_nxt        = {1'b0, scan_sel} + 6'd1;
    scan_index_next = (scan_nxt >= cnt) ? '0 : scan_nxt[IDX_W-1:0];

    // mode reload: every tick in other modes, once on entry to user run
    if (sys_mode == MODE_USER_RUN) begin
      if (prev_mode != MODE_USER_RUN) begin
        report_left_next = WINDOW_MS;
      end
    end else if (sys_mode != MODE_STANDBY) begin
      report_left_next = WINDOW_MS;
    end

    res.display_fault_id = shown_id;
    res.shutdown_request = shut;
    res.nostart_fault    = nost;
    res.report_time_ms   = report_left_next;
    res.latched_faults   = fault_flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index   <= '0;
      show_index   <= '0;
      fault_flags  <= '0;
      report_left  <= '0;
      show_elapsed <= '0;
      prev_mode    <= MODE_NONE;
    end else if (step) begin
      scan_index   <= scan_index_next;
      show_index   <= show_index_next;
      fault_flags  <= fault_flags_next;
      report_left  <= report_left_next;
      show_elapsed <= show_elapsed_next;
      prev_mode    <= sys_mode;
    end
  end

endmodule

/* sv/round_robin_fault_annunciator.sv */
// Top level: round-robin fault annunciator with tick, report and APB configuration ports.
//
//   port      | dir | kind           | beat
//   ----------+-----+----------------+-----------------------------------------
//   tick      | in  | valid/ready    | raw_faults[31:0], sys_mode[1:0]
//   report    | out | valid/ready    | display_fault_id, shutdown_request,
//             |     |                | nostart_fault, report_time_ms, latched
//   apb       | in  | psel/penable   | 5 x 32-bit registers at 4*index
//
// One tick beat per clock sustained while report.ready holds; a beat passes the
// input register, then the single update pass in rrfa_core, then the result register.
// Reset (rst, synchronous) clears scan/show state, flags and the window,
// loads register defaults; no clearing pass.
// A stalled report side holds the result register; the input register still
// takes one more beat, then tick.ready drops until the result moves.
`timescale 1ns / 1ps
module round_robin_fault_annunciator (
  input  logic        clk,
  input  logic        rst,
  rrfa_tick_if.sink   tick,
  rrfa_report_if.source report,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrfa_pkg::*;

  cfg_t        cfg;
  result_t     res;
  result_t     res_q;

  // input register
  logic        in_vld;
  logic [31:0] in_raw;
  logic [1:0]  in_mode;

  logic        out_vld;
  logic        fire;    // input register moves through the update pass
  logic        take;    // new tick beat accepted

  assign fire       = in_vld && (!out_vld || report.ready);
  assign tick.ready = !in_vld || fire;
  assign take       = tick.valid && tick.ready;

  rrfa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rrfa_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (fire),
    .raw_faults (in_raw),
    .sys_mode   (in_mode),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_raw  <= tick.raw_faults;
      in_mode <= tick.sys_mode;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (report.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign report.valid            = out_vld;
  assign report.display_fault_id = res_q.display_fault_id;
  assign report.shutdown_request = res_q.shutdown_request;
  assign report.nostart_fault    = res_q.nostart_fault;
  assign report.report_time_ms   = res_q.report_time_ms;
  assign report.latched_faults   = res_q.latched_faults;

`ifndef ASSERT_OFF
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> res_q.report_time_ms <= WINDOW_MS)
    else $error("report window above 5000 ms");

  a_other_mode_reload: assert property (@(posedge clk) disable iff (rst)
    fire && (in_mode != MODE_STANDBY) && (in_mode != MODE_USER_RUN)
      |=> out_vld && (res_q.report_time_ms == WINDOW_MS))
    else $error("other mode did not reload the window");

  a_shutdown_latched: assert property (@(posedge clk) disable iff (rst)
    out_vld && res_q.shutdown_request |-> res_q.latched_faults != 32'd0)
    else $error("shutdown request without a latched fault");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_vld && !fire |=> in_vld && $stable(in_raw) && $stable(in_mode))
    else $error("buffered tick lost while stalled");
`endif

endmodule

/* sim/tb_round_robin_fault_annunciator.sv */
// Testbench: self-checking random and directed test of the round-robin fault annunciator.
`timescale 1ns / 1ps
module tb_round_robin_fault_annunciator;
  import rrfa_pkg::*;

  // sys_mode 2 has no name in the package: "any other mode"
  localparam logic [1:0] MODE_OTHER = 2'd2;

  // Fault IDs of the populated table entries; spare entries carry 54 + index
  localparam int FAULT_IDS [21] = '{2, 3, 5, 6, 32, 40, 41, 44, 46, 48, 49, 50, 59, 63,
                                    68, 69, 70, 71, 72, 73, 74};

  // Predicts one report beat per tick beat and checks the beats coming out.
  class annunciator_scoreboard;
    // register copies
    int unsigned tick_ms;
    int unsigned entries_cfg;
    bit [31:0]   shut_mask;
    bit [31:0]   nost_mask;
    bit [31:0]   once_mask;
    // annunciator state
    int unsigned scan_idx;
    int unsigned show_idx;
    bit [31:0]   flags;
    int unsigned window_left;
    int unsigned show_ms;
    int unsigned shown;
    bit [1:0]    last_mode;

    result_t     expected_reports[$];
    int          errors;

    function new();
      tick_ms     = 8;
      entries_cfg = 21;
      shut_mask   = 32'h0003_FFFF;
      nost_mask   = 32'h0003_FFE0;
      once_mask   = 32'h001C_0010;
      scan_idx    = 0;
      show_idx    = 0;
      flags       = '0;
      window_left = 0;
      show_ms     = 0;
      shown       = 0;
      last_mode   = MODE_NONE;
      errors      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_TICK_PERIOD: tick_ms = val[7:0];
        REG_ENTRY_COUNT: entries_cfg = val[5:0];
        REG_SHUTDOWN:    shut_mask = val;
        REG_NOSTART:     nost_mask = val;
        REG_REPORT_ONCE: once_mask = val;
        default: ;
      endcase
    endfunction

    function void note_tick(logic [31:0] raw, logic [1:0] mode);
      int unsigned cnt;
      int unsigned idx;
      bit          fresh;
      result_t     want;
      want = '0;
      // entry count 0 acts as 1, anything above the table size is clamped
      cnt = entries_cfg;
      if (cnt < 1) cnt = 1;
      if (cnt > ENTRY_LIMIT) cnt = ENTRY_LIMIT;

      // display rotation, only while the window is open
      if (window_left > 0) begin
        if (show_idx >= cnt) show_idx = 0;
        if (flags[show_idx]) begin
          shown = (show_idx < 21) ? FAULT_IDS[show_idx] : 54 + show_idx;
          show_ms += tick_ms;
          if (show_ms > WINDOW_MS) begin
            show_ms  = 0;
            shown    = 0;
            show_idx = (show_idx + 1) % 32;
          end
        end else begin
          show_ms  = 0;
          shown    = 0;
          show_idx = (show_idx + 1) % 32;
        end
      end else begin
        show_ms  = 0;
        shown    = 0;
        show_idx = 0;
      end

      // window countdown, saturating at zero; period 0 freezes it
      window_left = (window_left > tick_ms) ? window_left - tick_ms : 0;

      // sample one entry; a stale scan index beyond the count acts as 0
      idx = (scan_idx < cnt) ? scan_idx : 0;
      if (raw[idx]) begin
        fresh = !flags[idx];
        want.shutdown_request = fresh && shut_mask[idx];
        want.nostart_fault    = nost_mask[idx];
        if (!once_mask[idx] || fresh) window_left = WINDOW_MS;
        flags[idx] = 1'b1;
      end else begin
        flags[idx] = 1'b0;
      end
      scan_idx = (idx + 1 >= cnt) ? 0 : idx + 1;

      // user run reloads on entry only; other modes (2 and 3) on every tick
      if (mode == MODE_USER_RUN) begin
        if (last_mode != MODE_USER_RUN) window_left = WINDOW_MS;
      end else if (mode != MODE_STANDBY) begin
        window_left = WINDOW_MS;
      end
      last_mode = mode;

      want.display_fault_id = shown[6:0];
      want.report_time_ms   = window_left[12:0];
      want.latched_faults   = flags;
      expected_reports.push_back(want);
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected report beat: %p", got);
        return;
      end
      want = expected_reports.pop_front();
      if (got.display_fault_id !== want.display_fault_id ||
          got.shutdown_request !== want.shutdown_request ||
          got.nostart_fault    !== want.nostart_fault    ||
          got.report_time_ms   !== want.report_time_ms   ||
          got.latched_faults   !== want.latched_faults) begin
        errors++;
        if (errors <= 10) begin
          $display("report mismatch at %0t", $realtime);
          $display("  expected id=%0d shut=%0b nost=%0b window=%0d latched=%h",
                   want.display_fault_id, want.shutdown_request, want.nostart_fault,
                   want.report_time_ms, want.latched_faults);
          $display("  actual   id=%0d shut=%0b nost=%0b window=%0d latched=%h",
                   got.display_fault_id, got.shutdown_request, got.nostart_fault,
                   got.report_time_ms, got.latched_faults);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rrfa_tick_if   tick_ch ();
  rrfa_report_if report_ch ();

  annunciator_scoreboard sb;

  // when set, neither side idles: back-to-back beats for the whole phase
  bit steady;

  round_robin_fault_annunciator dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .report  (report_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // APB write: setup cycle, then access cycle; the register takes the value
  // at the edge where psel/penable/pwrite/pready are all high. The bus then idles
  // before returning, so back-to-back writes never drive the bus twice in one step.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] period, input logic [5:0] cnt,
                            input logic [31:0] shut, input logic [31:0] nost,
                            input logic [31:0] once);
    apb_write(REG_TICK_PERIOD, {24'd0, period});
    apb_write(REG_ENTRY_COUNT, {26'd0, cnt});
    apb_write(REG_SHUTDOWN, shut);
    apb_write(REG_NOSTART, nost);
    apb_write(REG_REPORT_ONCE, once);
  endtask

  // Every tick beat yields a report beat, so the block is idle once the
  // expectation queue has drained; the extra wait after that covers the pipeline.
  task automatic wait_drained();
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One tick beat: optional gap, then hold valid until the handshake.
  // A gap of 0 keeps valid high, so back-to-back beats never toggle it.
  task automatic send_tick(input logic [31:0] raw, input logic [1:0] mode);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.raw_faults <= raw;
    tick_ch.sys_mode   <= mode;
    @(posedge clk);
    while (tick_ch.ready !== 1'b1) @(posedge clk);
    sb.note_tick(raw, mode);
  endtask

  task automatic end_ticks();
    tick_ch.valid <= 1'b0;
  endtask

  // Report side: random stall before each beat, then take it and check it.
  task automatic drain_reports();
    int      stall;
    result_t got;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        report_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      report_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(report_ch.valid === 1'b1 && report_ch.ready === 1'b1)) @(posedge clk);
      got.display_fault_id = report_ch.display_fault_id;
      got.shutdown_request = report_ch.shutdown_request;
      got.nostart_fault    = report_ch.nostart_fault;
      got.report_time_ms   = report_ch.report_time_ms;
      got.latched_faults   = report_ch.latched_faults;
      sb.check_report(got);
    end
  endtask

  // Random tick content. Density of the raw bits decides how often the
  // window is reloaded; the quiet style lets it run out so the display
  // rotation stops and restarts. Mode leans to standby so the window can close.
  task automatic random_ticks(input int n, input int style);
    logic [31:0] raw;
    logic [1:0]  mode;
    int          pick;
    for (int i = 0; i < n; i++) begin
      case (style)
        0:       raw = $urandom & $urandom & $urandom;
        1:       raw = $urandom;
        2:       raw = $urandom | $urandom | $urandom;
        default: raw = ($urandom_range(0, 15) == 0) ? $urandom : 32'd0;
      endcase
      pick = $urandom_range(0, 19);
      if (pick < 14)      mode = MODE_STANDBY;
      else if (pick < 17) mode = MODE_USER_RUN;
      else if (pick < 19) mode = MODE_OTHER;
      else                mode = MODE_NONE;
      send_tick(raw, mode);
    end
    end_ticks();
  endtask

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [7:0] period;
    logic [5:0] cnt;
    sb = new();
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    tick_ch.valid      <= 1'b0;
    tick_ch.raw_faults <= '0;
    tick_ch.sys_mode   <= MODE_STANDBY;
    report_ch.ready    <= 1'b0;
    steady = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      drain_reports();
    join_none

    // --- directed, reset register values ---
    send_tick(32'h0000_0000, MODE_STANDBY);   // nothing present, window closed
    send_tick(32'hFFFF_FFFF, MODE_STANDBY);   // new fault with shutdown attribute
    send_tick(32'hFFFF_FFFF, MODE_USER_RUN);  // entry to user run reloads
    send_tick(32'hFFFF_FFFF, MODE_USER_RUN);  // staying in user run does not
    send_tick(32'h0000_0010, MODE_OTHER);     // other mode reloads every tick
    send_tick(32'h0000_0010, MODE_NONE);      // mode value 3 counts as other
    send_tick(32'hAAAA_AAAA, MODE_STANDBY);
    send_tick(32'h5555_5555, MODE_STANDBY);
    send_tick(32'hFFFF_FFFF, MODE_STANDBY);   // no-startup attribute entries
    send_tick(32'hFFFF_FFFF, MODE_STANDBY);
    end_ticks();
    wait_drained();

    // --- directed: entry count 0 acts as 1, longest tick period, all attrs ---
    set_config(8'd255, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF, MODE_STANDBY);
    send_tick(32'hFFFF_FFFF, MODE_STANDBY);   // report-once: no reload on repeat
    send_tick(32'h0000_0000, MODE_STANDBY);
    send_tick(32'h0000_0001, MODE_OTHER);
    end_ticks();
    wait_drained();

    // --- directed: count above table size, tick period 0 freezes the window ---
    set_config(8'd0, 6'd63, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_tick(32'hFFFF_FFFF, MODE_USER_RUN);
    send_tick(32'h8000_0001, MODE_STANDBY);
    send_tick(32'h0000_0000, MODE_STANDBY);
    end_ticks();
    wait_drained();

    // --- show rotation: few entries, slow ticks, dense raw faults so a shown
    //     entry can run past the 5000 ms slot and hand over to the next ---
    steady = 1'b1;
    set_config(8'd255, 6'd3, $urandom, $urandom, 32'd0);
    random_ticks(80, 2);
    wait_drained();

    // --- random phases; registers keep changing between them, so latched
    //     bits above a shrunken count stay visible ---
    for (int ph = 0; ph < 9; ph++) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0:       period = 8'd0;
        1:       period = 8'd1;
        2:       period = 8'd255;
        default: period = $urandom_range(1, 255);
      endcase
      case ($urandom_range(0, 5))
        0:       cnt = 6'd0;
        1:       cnt = 6'd1;
        2:       cnt = 6'd32;
        3:       cnt = 6'd63;
        default: cnt = $urandom_range(1, 32);
      endcase
      set_config(period, cnt, pick_mask(), pick_mask(), pick_mask());
      random_ticks(80, $urandom_range(0, 3));
      wait_drained();
    end

    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
sv/rrfa_pkg.sv
sv/rrfa_tick_if.sv
sv/rrfa_report_if.sv
sv/rrfa_cfg.sv
sv/rrfa_core.sv
sv/round_robin_fault_annunciator.sv
sim/tb_round_robin_fault_annunciator.sv
